[rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-512 block compressor package
// Shared payload types, constants and round functions.
// ----------------------------------------------------------------------------
package sha512_pkg;

   typedef struct packed {
      logic [63:0] msg_word;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_digest_word;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       store_word;   // write message word into window
      logic       load_vars;    // copy chain value into working variables
      logic       do_round;     // run one round
      logic [6:0] round;        // round number
      logic       add_chain;    // add working variables into chain value
      logic       shift_out;    // rotate chain value by one word for output
      logic       reload_iv;    // reload initial hash value
   } dp_cmd_type;

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] INITIAL_HASH [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [6:0] LAST_ROUND = 7'd79;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] small_sig0(input logic [63:0] x);
      small_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sig1(input logic [63:0] x);
      small_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] big_sig0(input logic [63:0] x);
      big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sig1(input logic [63:0] x);
      big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

endpackage

[rtl/sha512_datapath.sv]
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Schedule shift window, working variables, round logic and chain value.
// ----------------------------------------------------------------------------
module sha512_datapath import sha512_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [63:0] msg_word,
   output logic [63:0] chain_head
);

   logic [63:0] win_ff [16];
   logic [63:0] win_in [16];
   logic [63:0] var_ff [8];
   logic [63:0] var_in [8];
   logic [63:0] chain_ff [8];
   logic [63:0] chain_in [8];
   logic [63:0] w_new, w_cur, t1, t2;

   // window: win_ff[0] is the oldest word, the current word of a round
   assign w_new = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
   assign w_cur = win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) win_in[i] = win_ff[i];
      if (cmd.store_word || cmd.do_round) begin
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
         win_in[15] = cmd.store_word ? msg_word : w_new;
      end
   end

   // round
   assign t1 = var_ff[7] + big_sig1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + ROUND_K[cmd.round] + w_cur;
   assign t2 = big_sig0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   always_comb begin
      for (int i = 0; i < 8; i++) var_in[i] = var_ff[i];
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) var_in[i] = chain_ff[i];
      end else if (cmd.do_round) begin
         var_in[0] = t1 + t2;
         var_in[1] = var_ff[0];
         var_in[2] = var_ff[1];
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3] + t1;
         var_in[5] = var_ff[4];
         var_in[6] = var_ff[5];
         var_in[7] = var_ff[6];
      end
   end

   // chain value: add, rotate out, or reload
   always_comb begin
      for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      priority if (cmd.reload_iv) begin
         for (int i = 0; i < 8; i++) chain_in[i] = INITIAL_HASH[i];
      end else if (cmd.add_chain) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + var_ff[i];
      end else if (cmd.shift_out) begin
         for (int i = 0; i < 7; i++) chain_in[i] = chain_ff[i + 1];
         chain_in[7] = chain_ff[0];
      end else begin
         // hold
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      var_ff <= var_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= INITIAL_HASH[i];
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain_head = chain_ff[0];

endmodule

[rtl/sha512_controller.sv]
// ----------------------------------------------------------------------------
// SHA-512 controller
// Counts words, sequences the 80 rounds and the eight-beat digest output.
// ----------------------------------------------------------------------------
module sha512_controller import sha512_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       end_of_message,
   output logic       busy,
   output dp_cmd_type cmd,
   output logic       out_valid,
   output logic [2:0] out_index
);

   typedef enum logic [1:0] {IDLE, ROUNDS, ADD, OUTPUT} state_type;

   state_type  state_ff;
   logic [3:0] count_ff;
   logic [6:0] round_ff;
   logic [2:0] oidx_ff;
   logic       last_ff;
   logic       accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != IDLE);

   always_comb begin
      cmd            = '0;
      cmd.store_word = accept;
      cmd.load_vars  = accept && (count_ff == 4'd15);
      cmd.do_round   = (state_ff == ROUNDS);
      cmd.round      = round_ff;
      cmd.add_chain  = (state_ff == ADD);
      cmd.shift_out  = (state_ff == OUTPUT);
      cmd.reload_iv  = (state_ff == OUTPUT) && (oidx_ff == 3'd7);
   end

   assign out_valid = (state_ff == OUTPUT);
   assign out_index = oidx_ff;

   // hold state, advance counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         round_ff <= '0;
         oidx_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  count_ff <= count_ff + 4'd1;
                  if (count_ff == 4'd15) begin
                     last_ff  <= end_of_message;
                     round_ff <= '0;
                     state_ff <= ROUNDS;
                  end
               end
            end
            ROUNDS: begin
               round_ff <= round_ff + 7'd1;
               if (round_ff == LAST_ROUND) state_ff <= ADD;
            end
            ADD: begin
               oidx_ff  <= '0;
               round_ff <= '0;
               state_ff <= last_ff ? OUTPUT : IDLE;
            end
            OUTPUT: begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ROUNDS) |-> !cmd.store_word) else $error("word stored during rounds");
   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ROUNDS && round_ff == LAST_ROUND) |=> (state_ff == ADD))
      else $error("rounds did not end");
   a_out_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid && oidx_ff == 3'd7) |=> !out_valid) else $error("digest too long");
`endif

endmodule

[rtl/sha512_block_compressor.sv]
// ----------------------------------------------------------------------------
// SHA-512 block compressor
// Takes padded message words and emits the 512-bit digest as eight beats.
// ----------------------------------------------------------------------------
// A word is taken on start while busy is low. The sixteenth word of a block
// starts the compression: 80 rounds at one per cycle, then an add into the
// chain value, with busy high throughout. With end_of_message on that word
// eight digest beats follow on consecutive cycles, rsp_valid high for each,
// and busy stays high through them; the receiver must take every beat as it
// comes.
module sha512_block_compressor import sha512_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   logic [63:0] chain_head;
   logic [2:0]  out_index;

   sha512_controller u_ctrl (
      .clock, .reset, .start,
      .end_of_message(req_data.end_of_message),
      .busy, .cmd,
      .out_valid(rsp_valid),
      .out_index
   );

   sha512_datapath u_dp (
      .clock, .reset, .cmd,
      .msg_word(req_data.msg_word),
      .chain_head
   );

   assign rsp_data.digest_word      = chain_head;
   assign rsp_data.word_index       = out_index;
   assign rsp_data.last_digest_word = (out_index == 3'd7);

endmodule

[tb/tb_sha512_block_compressor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 block compressor testbench
// Feeds padded message words, predicts the digest beats with an in-bench
// SHA-512 compression model and checks every beat in order.
// ----------------------------------------------------------------------------
module tb_sha512_block_compressor;
   import sha512_pkg::*;

   localparam int DRAIN_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_WORDS   = 264;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predictor state
   logic [63:0] sched [16];
   logic [63:0] chain [8];
   logic [3:0]  word_pos;
   rsp_type     digest_q [$];

   int errors;
   int beats_seen;
   int blocks_done;
   int digests_done;
   int idle_cycles;
   bit timed_out;

   // directed table: one row per message word, known first digest word where
   // the row closes a standard message
   typedef struct {
      logic [63:0] word;
      logic        eom;
      logic        kat_check;
      logic [63:0] kat;
   } word_row_type;

   word_row_type dir_rows [$];

   sha512_block_compressor u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] ror64(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // run the 80 rounds over the window and fold into the chain value
   task automatic compress_window();
      logic [63:0] v [8];
      logic [63:0] w, t1, t2, s0, s1;
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            s0 = ror64(sched[(t - 15) & 15], 1) ^ ror64(sched[(t - 15) & 15], 8)
                 ^ (sched[(t - 15) & 15] >> 7);
            s1 = ror64(sched[(t - 2) & 15], 19) ^ ror64(sched[(t - 2) & 15], 61)
                 ^ (sched[(t - 2) & 15] >> 6);
            sched[t & 15] = s1 + sched[(t - 7) & 15] + s0 + sched[t & 15];
         end
         w  = sched[t & 15];
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i - 1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   // absorb one accepted word, queue the digest when a final block closes
   task automatic absorb_word(req_type r);
      rsp_type d;
      sched[word_pos] = r.msg_word;
      if (word_pos != 4'd15) begin
         word_pos = word_pos + 4'd1;
         return;
      end
      word_pos = 4'd0;
      compress_window();
      blocks_done++;
      if (!r.end_of_message) return;
      for (int i = 0; i < 8; i++) begin
         d.digest_word      = chain[i];
         d.word_index       = 3'(i);
         d.last_digest_word = (i == 7);
         digest_q.push_back(d);
      end
      digests_done++;
      for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
   endtask

   // check digest beats against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest beat %h", $time, rsp_data);
            errors++;
         end else begin
            e = digest_q.pop_front();
            if (rsp_data.digest_word !== e.digest_word) begin
               $display("%0t: digest_word exp %h got %h", $time,
                        e.digest_word, rsp_data.digest_word);
               errors++;
            end
            if (rsp_data.word_index !== e.word_index) begin
               $display("%0t: word_index exp %0d got %0d", $time,
                        e.word_index, rsp_data.word_index);
               errors++;
            end
            if (rsp_data.last_digest_word !== e.last_digest_word) begin
               $display("%0t: last_digest_word exp %b got %b", $time,
                        e.last_digest_word, rsp_data.last_digest_word);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with no word accepted and no beat out
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL");
         $finish;
      end
   end

   // hold start until the word is taken, then predict
   task automatic send_word(logic [63:0] w, logic eom);
      req_type r;
      r.msg_word       = w;
      r.end_of_message = eom;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_word(r);
   endtask

   // drop start for a random gap, mostly short
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n == 0) return;
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int sent;
      int blk;
      int pos;
      logic eom;
      errors = 0; beats_seen = 0; blocks_done = 0; digests_done = 0;
      idle_cycles = 0; timed_out = 1'b0;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      word_pos = 4'd0;
      for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
      for (int i = 0; i < 16; i++) sched[i] = '0;

      // directed: "abc" padded block, then a zero-length message with the end
      // flag also set on an early word (ignored there)
      for (int i = 0; i < 16; i++) begin
         dir_rows.push_back('{(i == 0) ? 64'h6162638000000000 :
                              (i == 15) ? 64'h18 : 64'h0, i == 15,
                              i == 15, 64'hddaf35a193617aba});
      end
      for (int i = 0; i < 16; i++) begin
         dir_rows.push_back('{(i == 0) ? 64'h8000000000000000 : 64'h0,
                              (i == 3) || (i == 15),
                              i == 15, 64'hcf83e1357eefb8bd});
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) begin
         send_word(dir_rows[k].word, dir_rows[k].eom);
         // known answer: first digest word read off the standard
         if (dir_rows[k].kat_check) begin
            if (digest_q.size() != 8) begin
               $display("%0t: digest beats queued exp %0d got %0d", $time, 8,
                        digest_q.size());
               errors++;
            end else if (digest_q[0].digest_word !== dir_rows[k].kat) begin
               $display("%0t: known digest exp %h got %h", $time, dir_rows[k].kat,
                        digest_q[0].digest_word);
               errors++;
            end
         end
         if ($urandom_range(0, 1)) idle_gap();
      end

      // pause until every queued beat has come
      start <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);

      // random messages of one to three blocks, end flag on the final word;
      // stray flags on other words and non-final sixteenth words mixed in
      sent = 0;
      while (sent < RANDOM_WORDS || word_pos != 4'd0) begin
         blk = $urandom_range(1, 3);
         for (int b = 0; b < blk; b++) begin
            for (pos = 0; pos < 16; pos++) begin
               if (pos == 15) eom = (b == blk - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
               else eom = ($urandom_range(0, 7) == 0);
               send_word(rand_word(), eom);
               sent++;
               if ($urandom_range(0, 2) == 0) idle_gap();
            end
         end
      end
      start <= 1'b0;

      // drain
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d blocks, %0d digests, %0d beats checked.",
               blocks_done, digests_done, beats_seen);
      if (errors == 0 && digest_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
